// File: rtl/core/php_pkg.sv
// Shared types, constants and the helper function of the PTP common header parser.
package php_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 2048;
  localparam int unsigned HDR_BYTES       = 34;
  localparam int unsigned CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned HDR_IDX_W       = $clog2(HDR_BYTES);
  localparam int unsigned VER_W           = 4;
  localparam logic [VER_W-1:0] VER_RESET  = 4'd2;

  // Minimum messageLength per message type.
  localparam logic [15:0] MIN_LEN_EVENT   = 16'd44;
  localparam logic [15:0] MIN_LEN_DELAY   = 16'd54;
  localparam logic [15:0] MIN_LEN_MGMT    = 16'd48;
  localparam logic [15:0] MIN_LEN_SIGNAL  = 16'd64;
  localparam logic [15:0] MIN_LEN_HEADER  = 16'd34;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_MSG = 2'd1,
    ST_BAD_VER = 2'd2
  } status_e;

  typedef logic [HDR_BYTES-1:0][7:0] hdr_t;

  typedef struct packed {
    logic [7:0]  log_interval;
    logic [15:0] sequence_id;
    logic [15:0] src_port;
    logic [63:0] clock_identity;
    logic [31:0] type_specific;
    logic [63:0] correction_ns;
    logic [15:0] flag_bits;
    logic [7:0]  domain_number;
    logic [15:0] message_length;
    logic [11:0] sdo_id;
    logic [3:0]  message_type;
    status_e     status;
  } res_t;

  localparam int unsigned RES_W = $bits(res_t);

  // Completed frame handed from the capture stage to the decoder.
  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] frame_len;
  } frame_t;

  function automatic logic [15:0] body_min_len(input logic [3:0] kind);
    logic [15:0] len;
    case (kind)
      4'h0, 4'h1, 4'h8, 4'hC: len = MIN_LEN_EVENT;
      4'h2, 4'h3, 4'h9, 4'hA: len = MIN_LEN_DELAY;
      4'hB:                   len = MIN_LEN_SIGNAL;
      4'hD:                   len = MIN_LEN_MGMT;
      default:                len = MIN_LEN_HEADER;
    endcase
    return len;
  endfunction

endpackage

// File: rtl/core/ptp_header_parser.sv
// Top level of the PTP common header parser: stream ports and version register.
// A finished frame waits in the capture registers until the result buffer, which drives
// m_axis_tvalid, has room. Throughput: one item per cycle; the input stalls only when
// a finished frame waits and both entries of the two-entry result buffer are occupied.
// Reset (rst_ni low, asynchronous) clears the byte count, pending frame and
// buffer, and sets the expected version to 2; header bytes need no reset.
module ptp_header_parser import php_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration: expected versionPTP nibble.
  input  logic                 cfg_we_i,
  input  logic [VER_W-1:0]     cfg_wdata_i,
  // Input stream, one octet per item.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] data_byte
  input  logic                 s_axis_tlast,   // last_byte
  // Result stream, one item per frame.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [1:0] status, [5:2] message_type, [17:6] sdo_id, [33:18] message_length,
  // [41:34] domain_number, [57:42] flag_bits, [121:58] correction_ns,
  // [153:122] type_specific, [217:154] clock_identity, [233:218] src_port,
  // [249:234] sequence_id, [257:250] log_interval, [263:258] zero
  output logic [263:0]         m_axis_tdata
);

  logic [VER_W-1:0] ver_q;
  logic             in_acc;
  logic             buf_room;
  logic             frame_taken;
  frame_t           frame;
  hdr_t             hdr;
  res_t             res;
  res_t             out_res;

  // The user must write the version register only while the parser is idle; the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ver_q <= VER_RESET;
    end else if (cfg_we_i) begin
      ver_q <= cfg_wdata_i;
    end
  end

  // A finished frame moves into the result buffer as soon as it has room.
  // New octets are held off only while a finished frame still waits, since
  // the next frame would overwrite the header bytes the decoder is reading.
  assign frame_taken   = frame.done && buf_room;
  assign s_axis_tready = !frame.done || buf_room;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  php_capture u_capture (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_acc_i      (in_acc),
    .in_byte_i     (s_axis_tdata),
    .in_last_i     (s_axis_tlast),
    .frame_taken_i (frame_taken),
    .frame_o       (frame),
    .hdr_o         (hdr)
  );

  php_decode u_decode (
    .hdr_i       (hdr),
    .frame_len_i (frame.frame_len),
    .exp_ver_i   (ver_q),
    .res_o       (res)
  );

  php_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (frame_taken),
    .push_data_i (res),
    .room_o      (buf_room),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .data_o      (out_res)
  );

  // Fields are packed with status, the last member of res_t, in the lowest bits.
  assign m_axis_tdata = {6'd0,
                         out_res.log_interval,
                         out_res.sequence_id,
                         out_res.src_port,
                         out_res.clock_identity,
                         out_res.type_specific,
                         out_res.correction_ns,
                         out_res.flag_bits,
                         out_res.domain_number,
                         out_res.message_length,
                         out_res.sdo_id,
                         out_res.message_type,
                         out_res.status};

endmodule

// File: rtl/core/php_capture.sv
// Byte counter and header byte store of the PTP header parser.
module php_capture import php_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_acc_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       frame_taken_i,
  output frame_t     frame_o,
  output hdr_t       hdr_o
);

  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_inc;
  logic             done_q, done_d;
  logic [CNT_W-1:0] flen_q, flen_d;
  hdr_t             hdr_q;

  always_comb begin
    cnt_inc = (cnt_q < CNT_W'(MAX_FRAME_BYTES)) ? cnt_q + CNT_W'(1) : cnt_q;
    cnt_d   = cnt_q;
    done_d  = done_q && !frame_taken_i;
    flen_d  = flen_q;
    if (in_acc_i) begin
      cnt_d = in_last_i ? '0 : cnt_inc;
      if (in_last_i) begin
        done_d = 1'b1;
        flen_d = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    flen_q <= flen_d;
    if (in_acc_i && (cnt_q < CNT_W'(HDR_BYTES))) begin
      hdr_q[cnt_q[HDR_IDX_W-1:0]] <= in_byte_i;
    end
  end

  assign frame_o.done      = done_q;
  assign frame_o.frame_len = flen_q;
  assign hdr_o             = hdr_q;

endmodule

// File: rtl/core/php_decode.sv
// Header field extraction and message checks of the PTP header parser.
module php_decode import php_pkg::*; (
  input  hdr_t             hdr_i,
  input  logic [CNT_W-1:0] frame_len_i,
  input  logic [VER_W-1:0] exp_ver_i,
  output res_t             res_o
);

  logic [15:0] mlen;
  status_e     status;

  assign mlen = {hdr_i[2], hdr_i[3]};

  always_comb begin
    status = ST_OK;
    if (frame_len_i < CNT_W'(HDR_BYTES)) begin
      status = ST_BAD_MSG;
    end else if (hdr_i[1][3:0] != exp_ver_i) begin
      status = ST_BAD_VER;
    end else if ((mlen < body_min_len(hdr_i[0][3:0])) ||
                 (17'(mlen) > 17'(frame_len_i))) begin
      status = ST_BAD_MSG;
    end

    res_o = '0;
    res_o.status = status;
    if (status == ST_OK) begin
      res_o.message_type   = hdr_i[0][3:0];
      res_o.sdo_id         = {hdr_i[0][7:4], hdr_i[5]};
      res_o.message_length = mlen;
      res_o.domain_number  = hdr_i[4];
      res_o.flag_bits      = {hdr_i[6], hdr_i[7]};
      res_o.correction_ns  = {hdr_i[8], hdr_i[9], hdr_i[10], hdr_i[11],
                              hdr_i[12], hdr_i[13], hdr_i[14], hdr_i[15]};
      res_o.type_specific  = {hdr_i[16], hdr_i[17], hdr_i[18], hdr_i[19]};
      res_o.clock_identity = {hdr_i[20], hdr_i[21], hdr_i[22], hdr_i[23],
                              hdr_i[24], hdr_i[25], hdr_i[26], hdr_i[27]};
      res_o.src_port       = {hdr_i[28], hdr_i[29]};
      res_o.sequence_id    = {hdr_i[30], hdr_i[31]};
      res_o.log_interval   = hdr_i[33];
    end
  end

endmodule

// File: rtl/core/php_outbuf.sv
// Two-entry result buffer that decouples the decoder from the output stream.
module php_outbuf import php_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t push_data_i,
  output logic room_o,
  output logic valid_o,
  input  logic ready_i,
  output res_t data_o
);

  res_t       ent_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != 2'd0);
  assign room_o  = (cnt_q != 2'd2);
  assign data_o  = ent_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: dv/ptp_header_parser_tb.sv
// Self-checking testbench of the PTP common header parser: frames, version register, results.
module ptp_header_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import php_pkg::*;

  // PTP message types used to build frames. Values outside this list are still
  // sent, since the parser treats every unnamed type with the header minimum.
  typedef enum logic [3:0] {
    SYNC            = 4'h0,
    DREQ            = 4'h1,
    PDREQ           = 4'h2,
    PDRESP          = 4'h3,
    FUP             = 4'h8,
    DRESP           = 4'h9,
    PDRESP_FUP      = 4'hA,
    ANNOUNCE        = 4'hB,
    SIGNALING       = 4'hC,
    MANAGEMENT      = 4'hD,
    RESERVED_F      = 4'hF
  } msg_kind_e;

  // Content of the octets a frame carries besides type, version and length.
  typedef enum logic [1:0] {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES
  } fill_e;

  localparam int unsigned TAIL_CYCLES  = 8;
  localparam int unsigned END_WAIT_MAX = 5000;
  localparam realtime     RUN_LIMIT    = 10ms;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [3:0]   cfg_wdata_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;   // [7:0] data_byte
  logic         s_axis_tlast;   // last_byte
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [263:0] m_axis_tdata;   // res_t from bit 0 up, zero from bit RES_W up

  // Predictor state: octets of the open frame, the stored header and the
  // version the block is expected to hold.
  int unsigned  frame_bytes;
  logic [7:0]   hdr_seen [HDR_BYTES];
  logic [3:0]   exp_ver;
  res_t         awaited_headers [$];

  int unsigned  burst_left;
  int unsigned  fail_count;
  int unsigned  bytes_sent;
  int unsigned  frames_sent;
  int unsigned  oversized_frames;
  int unsigned  versions_used;
  int unsigned  results_checked;
  int unsigned  n_ok;
  int unsigned  n_bad_msg;
  int unsigned  n_bad_ver;

  ptp_header_parser i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shortest messageLength that each message type allows.
  function automatic logic [15:0] min_body_len(input logic [3:0] kind);
    logic [15:0] len;
    len = MIN_LEN_HEADER;
    case (kind)
      SYNC, DREQ, FUP, SIGNALING:                    len = MIN_LEN_EVENT;
      PDREQ, PDRESP, DRESP, PDRESP_FUP:              len = MIN_LEN_DELAY;
      ANNOUNCE:                                      len = MIN_LEN_SIGNAL;
      MANAGEMENT:                                    len = MIN_LEN_MGMT;
      default:                                       ;
    endcase
    return len;
  endfunction

  // Decodes the stored header of a frame of frame_len octets, as the block
  // must report it when the last octet arrives.
  function automatic res_t decode_header(input int unsigned frame_len);
    res_t        r;
    logic [15:0] msg_len;
    r = '0;
    msg_len = {hdr_seen[2], hdr_seen[3]};
    // The checks run in a fixed order: a short frame wins over a wrong
    // version, and a wrong version wins over a bad messageLength.
    if (frame_len < HDR_BYTES) begin
      r.status = ST_BAD_MSG;
    end else if (hdr_seen[1][3:0] != exp_ver) begin
      r.status = ST_BAD_VER;
    end else if (msg_len < min_body_len(hdr_seen[0][3:0]) || msg_len > frame_len) begin
      r.status = ST_BAD_MSG;
    end else begin
      r.status         = ST_OK;
      r.message_type   = hdr_seen[0][3:0];
      r.sdo_id         = {hdr_seen[0][7:4], hdr_seen[5]};
      r.message_length = msg_len;
      r.domain_number  = hdr_seen[4];
      r.flag_bits      = {hdr_seen[6], hdr_seen[7]};
      r.correction_ns  = {hdr_seen[8], hdr_seen[9], hdr_seen[10], hdr_seen[11],
                          hdr_seen[12], hdr_seen[13], hdr_seen[14], hdr_seen[15]};
      r.type_specific  = {hdr_seen[16], hdr_seen[17], hdr_seen[18], hdr_seen[19]};
      r.clock_identity = {hdr_seen[20], hdr_seen[21], hdr_seen[22], hdr_seen[23],
                          hdr_seen[24], hdr_seen[25], hdr_seen[26], hdr_seen[27]};
      r.src_port       = {hdr_seen[28], hdr_seen[29]};
      r.sequence_id    = {hdr_seen[30], hdr_seen[31]};
      r.log_interval   = hdr_seen[33];
    end
    return r;
  endfunction

  // Follows one accepted octet: keep it if it belongs to the header, count it
  // with saturation, and on the last octet queue the result the block owes.
  task automatic track_byte(input logic [7:0] b, input logic last);
    res_t r;
    if (frame_bytes < HDR_BYTES) begin
      hdr_seen[frame_bytes] = b;
    end
    if (frame_bytes < MAX_FRAME_BYTES) begin
      frame_bytes++;
    end
    bytes_sent++;
    if (last) begin
      r = decode_header(frame_bytes);
      case (r.status)
        ST_OK:      n_ok++;
        ST_BAD_MSG: n_bad_msg++;
        default:    n_bad_ver++;
      endcase
      awaited_headers.push_back(r);
      frame_bytes = 0;
    end
  endtask

  // Sends one item. The sender works in bursts; between bursts it drops
  // tvalid for a random pause, sometimes none. Entered and left at
  // a falling edge.
  task automatic push_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    s_axis_tlast  = last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    track_byte(b, last);
    @(negedge clk_i);
  endtask

  // Sends a frame of nbytes octets with the given type, version nibble and
  // messageLength; the rest is random, all zeros or all ones.
  task automatic send_frame(input logic [3:0] kind, input logic [3:0] ver,
                            input logic [15:0] msg_len, input int unsigned nbytes,
                            input fill_e fill);
    logic [7:0] b;
    for (int unsigned i = 0; i < nbytes; i++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hFF;
        default:   b = 8'($urandom());
      endcase
      case (i)
        0:       b[3:0] = kind;
        1:       b[3:0] = ver;
        2:       b = msg_len[15:8];
        3:       b = msg_len[7:0];
        default: ;
      endcase
      push_byte(b, i == nbytes - 1);
    end
    frames_sent++;
    if (nbytes > MAX_FRAME_BYTES) begin
      oversized_frames++;
    end
  endtask

  // Stops the sender until every awaited result has come, then lets the
  // pipeline settle so that the block is idle.
  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (awaited_headers.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
  endtask

  // Writes the expected version register; only called while the block is idle.
  task automatic write_version(input logic [3:0] v);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    exp_ver     = v;
    versions_used++;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // Result checker: every accepted result is matched against the oldest
  // awaited header, field by field.
  always @(posedge clk_i) begin : result_check
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = res_t'(m_axis_tdata[RES_W-1:0]);
      if (awaited_headers.size() == 0) begin
        $error("result with no frame awaiting it: tdata 0x%0h", m_axis_tdata);
        fail_count++;
      end else begin
        want = awaited_headers.pop_front();
        results_checked++;
        check_field("status",         64'(want.status),         64'(got.status));
        check_field("message_type",   64'(want.message_type),   64'(got.message_type));
        check_field("sdo_id",         64'(want.sdo_id),         64'(got.sdo_id));
        check_field("message_length", 64'(want.message_length), 64'(got.message_length));
        check_field("domain_number",  64'(want.domain_number),  64'(got.domain_number));
        check_field("flag_bits",      64'(want.flag_bits),      64'(got.flag_bits));
        check_field("correction_ns",  want.correction_ns,       got.correction_ns);
        check_field("type_specific",  64'(want.type_specific),  64'(got.type_specific));
        check_field("clock_identity", want.clock_identity,      got.clock_identity);
        check_field("src_port",       64'(want.src_port),       64'(got.src_port));
        check_field("sequence_id",    64'(want.sequence_id),    64'(got.sequence_id));
        check_field("log_interval",   64'(want.log_interval),   64'(got.log_interval));
        check_field("tdata padding",  64'(0),                   64'(m_axis_tdata[263:RES_W]));
      end
    end
  end

  // The receiver stalls on a rotating 16-bit pattern, replaced by one drawn at random:
  // always ready, random, long stall runs, or alternating ready and stall.
  logic [15:0] ready_pattern = 16'hFFFF;
  int unsigned pattern_age   = 0;

  always @(negedge clk_i) begin
    pattern_age++;
    if (pattern_age % 64 == 0) begin
      case ($urandom_range(0, 3))
        0:       ready_pattern = 16'hFFFF;
        1:       ready_pattern = 16'($urandom()) | 16'h0001;
        2:       ready_pattern = 16'h00FF;
        default: ready_pattern = 16'h5555;
      endcase
    end
    ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
    m_axis_tready = ready_pattern[0];
  end

  // The register must come out of reset at version 2.
  task automatic test_reset_version();
    send_frame(SYNC, VER_RESET, 16'd44, 44, FILL_RANDOM);
    send_frame(ANNOUNCE, VER_RESET + 4'd1, 16'd64, 64, FILL_RANDOM);
  endtask

  // All-ones and all-zero headers reach every field but messageLength at both ends of its range.
  task automatic test_field_extremes();
    wait_drained();
    write_version(4'hF);
    send_frame(RESERVED_F, 4'hF, 16'd60, 60, FILL_ONES);
    wait_drained();
    write_version(4'h0);
    send_frame(SYNC, 4'h0, 16'd44, 44, FILL_ZERO);
  endtask

  // One frame per message type value, with messageLength at the type's minimum and the
  // frame four octets longer; on odd type values with a minimum above the header it is one short.
  task automatic test_message_kinds();
    logic [15:0] min_len;
    logic [15:0] msg_len;
    wait_drained();
    write_version(VER_RESET);
    for (int k = 0; k < 16; k++) begin
      min_len = min_body_len(4'(k));
      msg_len = (k % 2 == 1 && min_len > HDR_BYTES) ? min_len - 16'd1 : min_len;
      send_frame(4'(k), VER_RESET, msg_len, min_len + 4, FILL_RANDOM);
    end
  endtask

  // Short frames, a frame of exactly the header size, and messageLength
  // around the number of octets received.
  task automatic test_length_limits();
    send_frame(SYNC, VER_RESET, 16'd44, 1, FILL_RANDOM);
    send_frame(SYNC, VER_RESET, 16'd33, 33, FILL_RANDOM);
    send_frame(RESERVED_F, VER_RESET, 16'd34, 34, FILL_RANDOM);
    send_frame(FUP, VER_RESET, 16'd51, 50, FILL_RANDOM);
    send_frame(FUP, VER_RESET, 16'd50, 50, FILL_RANDOM);
    send_frame(MANAGEMENT, VER_RESET, 16'hFFFF, 80, FILL_RANDOM);
  endtask

  // A frame one octet past the maximum size: the count saturates, so a
  // messageLength equal to the octets sent is still too long.
  task automatic test_oversized_frames();
    send_frame(DRESP, VER_RESET, 16'(MAX_FRAME_BYTES + 1), MAX_FRAME_BYTES + 1,
               FILL_RANDOM);
  endtask

  // Several register settings, each with a matching and a mismatching frame,
  // plus the precedence of the checks.
  task automatic test_version_register();
    logic [3:0] ver;
    for (int s = 0; s < 3; s++) begin
      ver = (s == 0) ? 4'h5 : 4'($urandom());
      wait_drained();
      write_version(ver);
      send_frame(PDREQ, ver, 16'd54, 60, FILL_RANDOM);
      send_frame(PDREQ, ver ^ 4'($urandom_range(1, 15)), 16'd54, 60, FILL_RANDOM);
    end
    // A short frame with a wrong version reports the length.
    send_frame(SYNC, exp_ver ^ 4'h8, 16'd44, 20, FILL_RANDOM);
    // A wrong version wins over a bad messageLength.
    send_frame(SYNC, exp_ver ^ 4'h1, 16'd10, 44, FILL_RANDOM);
  endtask

  // About half of the frames are well formed, with random content; the rest carry a wrong
  // version, a bad messageLength, too few octets, or are pure noise. Halfway
  // the sender waits for every result and the version changes.
  task automatic test_random_traffic();
    int unsigned start_bytes;
    int unsigned nbytes;
    logic [3:0]  kind;
    logic [3:0]  ver;
    logic [15:0] min_len;
    logic [15:0] msg_len;
    bit          paused;
    start_bytes = bytes_sent;
    paused      = 1'b0;
    wait_drained();
    write_version(4'($urandom()));
    while (bytes_sent - start_bytes < 600) begin
      if (!paused && bytes_sent - start_bytes >= 300) begin
        wait_drained();
        write_version(4'($urandom()));
        paused = 1'b1;
      end
      kind    = 4'($urandom());
      min_len = min_body_len(kind);
      nbytes  = $urandom_range(min_len, min_len + 30);
      msg_len = 16'($urandom_range(min_len, nbytes));
      ver     = exp_ver;
      case ($urandom_range(0, 9))
        0:       ver = exp_ver ^ 4'($urandom_range(1, 15));
        1:       msg_len = 16'($urandom_range(0, min_len - 1));
        2:       msg_len = 16'($urandom_range(nbytes + 1, 16'hFFFF));
        3:       nbytes = $urandom_range(1, 33);
        4: begin
          ver     = 4'($urandom());
          msg_len = 16'($urandom());
          nbytes  = $urandom_range(1, 60);
        end
        default: ;
      endcase
      send_frame(kind, ver, msg_len, nbytes, FILL_RANDOM);
    end
  endtask

  initial begin : main_sequence
    int unsigned end_wait;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    frame_bytes   = 0;
    exp_ver       = VER_RESET;
    burst_left    = 0;
    fail_count    = 0;
    bytes_sent    = 0;
    frames_sent   = 0;
    oversized_frames = 0;
    versions_used = 0;
    results_checked = 0;
    n_ok          = 0;
    n_bad_msg     = 0;
    n_bad_ver     = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_version();
    test_field_extremes();
    test_message_kinds();
    test_length_limits();
    test_oversized_frames();
    test_version_register();
    test_random_traffic();

    // Let the last results drain, bounded, and then keep watching the result
    // stream so that any result that nobody asked for shows.
    s_axis_tvalid = 1'b0;
    end_wait = 0;
    while (awaited_headers.size() != 0 && end_wait < END_WAIT_MAX) begin
      @(negedge clk_i);
      end_wait++;
    end
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (awaited_headers.size() != 0) begin
      $error("%0d expected results never arrived", awaited_headers.size());
      fail_count++;
    end

    $display("Sent %0d octets in %0d frames (%0d oversized) under %0d version settings.",
             bytes_sent, frames_sent, oversized_frames, versions_used + 1);
    $display("Compared %0d results: %0d good headers, %0d bad length, %0d bad version.",
             results_checked, n_ok, n_bad_msg, n_bad_ver);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT);
    $display("Run stopped by the watchdog with %0d results outstanding.",
             awaited_headers.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
